// File: sv/cleb_pkg.sv
`default_nettype none
package cleb_pkg;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = 7;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_EOT   = 8'h04;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   localparam logic STAT_ZERO_LEN = 1'b0;
   localparam logic STAT_EMPTY    = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_ECHO  = 6'b000100,
      ST_STAT  = 6'b001000,
      ST_RADDR = 6'b010000,
      ST_RDATA = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SLOT_PASS = 2'd0,
      SLOT_INC  = 2'd1,
      SLOT_DEC  = 2'd2
   } slot_op_type;

   typedef enum logic [1:0] {
      ECHO_PLAIN   = 2'd0,
      ECHO_ERASE   = 2'd1,
      ECHO_NEWLINE = 2'd2
   } echo_mode_type;

   typedef struct packed {
      logic eq;
      logic hit;
   } slot_flags_type;

   function automatic logic ends_line(input logic [7:0] c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic is_erase(input logic [7:0] c);
      return (c == CH_BS) || (c == CH_DEL);
   endfunction

endpackage
`default_nettype wire

// File: sv/canonical_line_editor_buffer_top.sv
// Canonical line editor on a ring buffer.
// Request channel (req_*): tuser 0 = typed character, tuser 1 = read request.
// Response channel (rsp_*): echo bytes, popped bytes or an end status;
// tlast marks the final response of each request.
// A request is taken only when the sequencer is idle. In the cycle after
// acceptance the pointers are checked by the shared slot unit; a character
// then gives its echo bytes at one per cycle while rsp_tready does not stall
// the output (0 to 3 responses). A read pops each byte in ST_RADDR, which
// steps the head pointer and addresses the buffer memory, then in ST_RDATA,
// which takes the registered read data once the output is free; the next
// byte is addressed only after that. A request answered by nothing (dropped
// character, idle backspace) frees the block straight from the check.
// Reset clears the head, raw tail and cooked tail to slot 0; buffer contents
// stay undefined and are never read before written, so there is no clearing.
// When rsp_tready is low the output register holds and the sequencer waits;
// no response is lost or repeated.
`default_nettype none
module canonical_line_editor_buffer_top import cleb_pkg::*; #(
   parameter int BUF_DEPTH = 128,
   parameter int MAX_READ  = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // in_char[7:0], read_len[14:8]
   input  wire logic                   req_tuser,  // req_type
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,  // out_byte[7:0], out_keep[8],
                                                   // out_status[9], read_count[16:10]
   output logic      [1:0]             rsp_tuser,  // out_kind
   output logic                        rsp_tlast   // out_last
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam logic [6:0] READ_MAX = 7'(MAX_READ);

   state_type      state_ff, state_in;
   logic           type_ff, type_in;
   logic [7:0]     char_ff, char_in;
   logic [6:0]     len_ff, len_in;
   logic [6:0]     cnt_ff, cnt_in;
   echo_mode_type  mode_ff, mode_in;
   logic [1:0]     idx_ff, idx_in;
   logic           stat_ff, stat_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [AW-1:0]  raw_ff, raw_in;
   logic [AW-1:0]  cooked_ff, cooked_in;

   logic           valid_ff, valid_in;
   logic [1:0]     kind_ff, kind_in;
   logic [7:0]     byte_ff, byte_in;
   logic           keep_ff, keep_in;
   logic           status_ff, status_in;
   logic [6:0]     count_ff, count_in;
   logic           last_ff, last_in;

   slot_op_type    alu_op;
   logic [AW-1:0]  alu_a;
   logic [AW-1:0]  alu_b;
   logic [AW-1:0]  alu_res;
   slot_flags_type alu_flags;

   logic           mem_we;
   logic           mem_re;
   logic [7:0]     mem_rdata;

   logic           out_free;
   logic           load;
   logic [6:0]     cnt_next;
   logic [6:0]     req_len;

   cleb_slot_alu #(.DEPTH(BUF_DEPTH), .AW(AW)) u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .res   (alu_res),
      .flags (alu_flags)
   );

   cleb_ram #(.DEPTH(BUF_DEPTH), .AW(AW)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (alu_res),
      .wdata (char_ff),
      .re    (mem_re),
      .raddr (alu_res),
      .rdata (mem_rdata)
   );

   assign out_free = !valid_ff || rsp_tready;
   assign cnt_next = cnt_ff + 7'd1;
   assign req_len  = req_tdata[14:8];

   always_comb begin
      state_in  = state_ff;
      type_in   = type_ff;
      char_in   = char_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      idx_in    = idx_ff;
      stat_in   = stat_ff;
      head_in   = head_ff;
      raw_in    = raw_ff;
      cooked_in = cooked_ff;
      alu_op    = SLOT_PASS;
      alu_a     = head_ff;
      alu_b     = cooked_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      load      = 1'b0;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      keep_in   = 1'b0;
      status_in = 1'b0;
      count_in  = 7'd0;
      last_in   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser;
               char_in  = req_tdata[7:0];
               len_in   = (req_len > READ_MAX) ? READ_MAX : req_len;
               cnt_in   = 7'd0;
               idx_in   = 2'd0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (type_ff == REQ_CHAR) begin
               if (is_erase(char_ff)) begin
                  alu_op = SLOT_DEC;
                  alu_a  = raw_ff;
                  alu_b  = cooked_ff;
                  if (alu_flags.eq) begin
                     state_in = ST_IDLE;
                  end else begin
                     raw_in   = alu_res;
                     mode_in  = ECHO_ERASE;
                     state_in = ST_ECHO;
                  end
               end else begin
                  alu_op = SLOT_INC;
                  alu_a  = raw_ff;
                  alu_b  = head_ff;
                  if (alu_flags.hit) begin
                     state_in = ST_IDLE;
                  end else begin
                     raw_in   = alu_res;
                     mem_we   = 1'b1;
                     state_in = ST_ECHO;
                     if (ends_line(char_ff)) begin
                        cooked_in = alu_res;
                        mode_in   = ECHO_NEWLINE;
                     end else begin
                        mode_in = ECHO_PLAIN;
                     end
                  end
               end
            end else begin
               if (len_ff == 7'd0) begin
                  stat_in  = STAT_ZERO_LEN;
                  state_in = ST_STAT;
               end else if (alu_flags.eq) begin
                  stat_in  = STAT_EMPTY;
                  state_in = ST_STAT;
               end else begin
                  state_in = ST_RADDR;
               end
            end
         end
         ST_ECHO: begin
            if (out_free) begin
               load    = 1'b1;
               kind_in = KIND_ECHO;
               idx_in  = idx_ff + 2'd1;
               case (mode_ff)
                  ECHO_ERASE: begin
                     byte_in = (idx_ff == 2'd1) ? CH_SPACE : char_ff;
                     last_in = (idx_ff == 2'd2);
                  end
                  ECHO_NEWLINE: begin
                     byte_in = (idx_ff == 2'd0) ? CH_CR : CH_LF;
                     last_in = (idx_ff == 2'd1);
                  end
                  default: begin
                     byte_in = char_ff;
                     last_in = 1'b1;
                  end
               endcase
               if (last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STAT: begin
            if (out_free) begin
               load      = 1'b1;
               kind_in   = KIND_END;
               byte_in   = 8'd0;
               status_in = stat_ff;
               last_in   = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_RADDR: begin
            alu_op   = SLOT_INC;
            alu_a    = head_ff;
            head_in  = alu_res;
            mem_re   = 1'b1;
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            // head now points at the popped slot
            if (out_free) begin
               load     = 1'b1;
               kind_in  = KIND_READ;
               byte_in  = mem_rdata;
               keep_in  = (mem_rdata != CH_EOT);
               count_in = cnt_next;
               cnt_in   = cnt_next;
               last_in  = (cnt_next == len_ff) || ends_line(mem_rdata) || alu_flags.eq;
               state_in = last_in ? ST_IDLE : ST_RADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         raw_ff    <= '0;
         cooked_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         raw_ff    <= raw_in;
         cooked_ff <= cooked_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      char_ff <= char_in;
      len_ff  <= len_in;
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      idx_ff  <= idx_in;
      stat_ff <= stat_in;
      if (load) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         keep_ff   <= keep_in;
         status_ff <= status_in;
         count_ff  <= count_in;
         last_ff   <= last_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), count_ff, status_ff, keep_ff, byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// File: sv/cleb_ram.sv
`default_nettype none
module cleb_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: sv/cleb_slot_alu.sv
`default_nettype none
module cleb_slot_alu import cleb_pkg::*; #(
   parameter int DEPTH = 128,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire slot_op_type    op,
   input  wire logic [AW-1:0]  a,
   input  wire logic [AW-1:0]  b,
   output logic      [AW-1:0]  res,
   output slot_flags_type      flags
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   // modular step for any depth
   always_comb begin
      case (op)
         SLOT_INC: res = (a == LAST) ? '0 : a + AW'(1);
         SLOT_DEC: res = (a == '0) ? LAST : a - AW'(1);
         default:  res = a;
      endcase
      flags.eq  = (a == b);
      flags.hit = (res == b);
   end

endmodule
`default_nettype wire

// File: sv/cleb_checker.sv
`default_nettype none
module cleb_checker import cleb_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]             rsp_tuser,
   input wire logic                   rsp_tlast
);

   // one request at a time: busy right after taking one
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_END) |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("end status not alone");

   a_echo_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ECHO) |-> (rsp_tdata[RSP_TDATA_W-1:8] == '0))
      else $error("echo carries read fields");

endmodule

bind canonical_line_editor_buffer_top cleb_checker u_cleb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
